/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fmt_pkg.sv */
package fmt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Request modes.
  localparam logic [1:0] MODE_INJ_INST = 2'd0;
  localparam logic [1:0] MODE_INJ_MASK = 2'd1;
  localparam logic [1:0] MODE_READ     = 2'd2;
  localparam logic [1:0] MODE_CLEAR    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Fault types.
  localparam logic [7:0] TYPE_OK    = 8'd0;
  localparam logic [7:0] TYPE_OFF   = 8'd1;
  localparam logic [7:0] TYPE_STUCK = 8'd2;
  localparam logic [7:0] TYPE_WRONG = 8'd3;

  // Last unit code of each catalogue group.
  localparam logic [7:0] UNIT_DISTANCE = 8'd4;
  localparam logic [7:0] UNIT_MOTOR    = 8'd7;
  localparam logic [7:0] UNIT_BATTERY  = 8'd9;

  localparam logic [7:0]  INST_ALL  = 8'd0;
  localparam logic [7:0]  INST_LAST = 8'd16;
  localparam logic [15:0] MASK_ALL  = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  unit;
    logic [7:0]  ftype;
    logic [15:0] mask;
  } slot_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  unit;
    logic [7:0]  fault_code;
    logic [7:0]  instance_req;
    logic [15:0] select_mask;
    logic [3:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_unit;
    logic [7:0]  entry_type;
    logic [15:0] entry_mask;
    logic [4:0]  entry_count;
    logic        changed;
  } rsp_t;

  // Decoded request handed to the table engine.
  typedef struct packed {
    logic [1:0]  op;
    logic        supported;
    logic [7:0]  unit;
    logic [7:0]  ftype;
    logic [15:0] mask;
    logic [3:0]  read_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_WRITE,
    ENG_APPEND,
    ENG_READ,
    ENG_DONE
  } eng_state_t;

  function automatic logic pair_known(input logic [7:0] u, input logic [7:0] t);
    logic ok;
    if (u <= UNIT_DISTANCE) begin
      ok = (t <= TYPE_STUCK);
    end else if (u <= UNIT_MOTOR) begin
      ok = (t <= TYPE_WRONG);
    end else if (u <= UNIT_BATTERY) begin
      ok = (t <= TYPE_OFF);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [15:0] sel_to_mask(input logic [7:0] n);
    logic [3:0]  sh;
    logic [15:0] m;
    sh = 4'(n - 8'd1);
    if (n == INST_ALL) begin
      m = MASK_ALL;
    end else if (n > INST_LAST) begin
      m = '0;
    end else begin
      m = 16'd1 << sh;
    end
    return m;
  endfunction

endpackage

/* rtl/fmt_slot_ram.sv */
module fmt_slot_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fmt_engine.sv */
module fmt_engine import fmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  input  logic ack,
  output logic done,
  output rsp_t result
);

  eng_state_t state, state_next;

  cmd_t             cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic             flag;
  logic             dv;
  logic             hit;
  logic [1:0]       res_status;
  slot_t            res_slot;

  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_t            wdata;
  logic [IDX_W-1:0] raddr;
  slot_t            rdata;

  fmt_slot_ram #(
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(IDX_W),
    .DATA_W($bits(slot_t))
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Evaluation of the slot that the memory returns this cycle.
  logic        strip_c, hit_c, gain_c, keep_c;
  logic [15:0] nm_c;
  logic        in_pass, issue, pass_end, reject, append, idx_ok;

  always_comb begin
    strip_c = (rdata.unit == cur.unit) &&
              ((cur.ftype == TYPE_OK) || (rdata.ftype != cur.ftype)) &&
              ((rdata.mask & cur.mask) != '0);
    hit_c   = (cur.ftype != TYPE_OK) && (rdata.unit == cur.unit) &&
              (rdata.ftype == cur.ftype);
    gain_c  = hit_c && ((rdata.mask & cur.mask) != cur.mask);
    if (hit_c) begin
      nm_c = rdata.mask | cur.mask;
    end else if (strip_c) begin
      nm_c = rdata.mask & ~cur.mask;
    end else begin
      nm_c = rdata.mask;
    end
    keep_c = (nm_c != '0);
  end

  assign in_pass  = (state == ENG_SCAN) || (state == ENG_WRITE);
  assign issue    = in_pass && (rd_ptr < count);
  assign pass_end = in_pass && !issue && !dv;
  assign append   = (cur.ftype != TYPE_OK) && !hit;
  assign reject   = append && (wr_ptr == CNT_W'(TABLE_DEPTH));
  assign idx_ok   = (8'(cmd.read_index) < 8'(count));

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: begin
        if (start) begin
          unique case (cmd.op)
            MODE_INJ_INST, MODE_INJ_MASK: begin
              state_next = (cmd.supported && (cmd.mask != '0)) ? ENG_SCAN : ENG_DONE;
            end
            MODE_READ: begin
              state_next = idx_ok ? ENG_READ : ENG_DONE;
            end
            MODE_CLEAR: begin
              state_next = ENG_DONE;
            end
          endcase
        end
      end
      ENG_SCAN: begin
        if (pass_end) begin
          state_next = reject ? ENG_DONE : ENG_WRITE;
        end
      end
      ENG_WRITE: begin
        if (pass_end) begin
          state_next = append ? ENG_APPEND : ENG_DONE;
        end
      end
      ENG_APPEND: begin
        state_next = ENG_DONE;
      end
      ENG_READ: begin
        state_next = ENG_DONE;
      end
      ENG_DONE: begin
        if (ack) begin
          state_next = ENG_IDLE;
        end
      end
      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr[IDX_W-1:0];
    wdata = '{unit: rdata.unit, ftype: rdata.ftype, mask: nm_c};
    raddr = (state == ENG_IDLE) ? IDX_W'(cmd.read_index) : rd_ptr[IDX_W-1:0];
    unique case (state)
      ENG_WRITE: begin
        we = dv && keep_c;
      end
      ENG_APPEND: begin
        we    = 1'b1;
        wdata = '{unit: cur.unit, ftype: cur.ftype, mask: cur.mask};
      end
      default: begin
        we = 1'b0;
      end
    endcase
    done   = (state == ENG_DONE);
    result = '{status:      res_status,
               entry_unit:  res_slot.unit,
               entry_type:  res_slot.ftype,
               entry_mask:  res_slot.mask,
               entry_count: 5'(count),
               changed:     flag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      count <= '0;
      flag  <= 1'b0;
      dv    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ENG_IDLE: begin
          if (start) begin
            cur        <= cmd;
            rd_ptr     <= '0;
            wr_ptr     <= '0;
            dv         <= 1'b0;
            hit        <= 1'b0;
            res_slot   <= '0;
            res_status <= ((cmd.op == MODE_INJ_INST || cmd.op == MODE_INJ_MASK) &&
                           !cmd.supported) ? ST_UNSUP : ST_OK;
            if (cmd.op == MODE_CLEAR) begin
              flag <= 1'b0;
            end
          end
        end
        ENG_SCAN, ENG_WRITE: begin
          dv <= issue;
          if (issue) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          if (dv) begin
            if (keep_c) begin
              wr_ptr <= wr_ptr + CNT_W'(1);
            end
            if (hit_c) begin
              hit <= 1'b1;
            end
            if ((state == ENG_WRITE) && (strip_c || gain_c)) begin
              flag <= 1'b1;
            end
          end
          if (pass_end) begin
            rd_ptr <= '0;
            if (state == ENG_SCAN) begin
              wr_ptr <= '0;
              hit    <= 1'b0;
              if (reject) begin
                res_status <= ST_FULL;
              end
            end else begin
              count <= wr_ptr;
            end
          end
        end
        ENG_APPEND: begin
          count <= wr_ptr + CNT_W'(1);
          flag  <= 1'b1;
        end
        ENG_READ: begin
          res_slot <= rdata;
        end
        default: begin
          dv <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/fault_mode_table_unit.sv */
// Flow: a read of a live slot passes through the READ and DONE states before its result is
// registered; a flag clear, a catalogue reject, an empty mask or a read past the entry count
// goes straight to DONE. An inject's duration grows with the live entries, set by a dry pass
// through the slot memory and, unless the request is rejected, a second pass (one read port,
// one slot a cycle, registered read).
// Reset (synchronous, rst high) empties the table and clears the changed flag.
`include "assert_macros.svh"

// The fault table is kept compacted in a single-port-read, single-port-write slot
// memory inside the engine. An inject first runs a dry pass over the live slots to
// learn whether the request would leave the table overfull; a request that would is
// rejected without any write, which is how the rollback is realized. Otherwise a
// second pass strips the addressed instances, writes surviving slots back at a lagging
// write pointer (never ahead of the read pointer, so no forwarding is needed), merges
// into the matching slot and finally appends a new slot when a type other than ok found no match.
//
// This level decodes the incoming transaction (catalogue check and instance number to
// mask conversion) and holds the result register, so a new request can be taken while
// the previous result still waits for the consumer.
module fault_mode_table_unit import fmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic busy;
  logic start;
  logic done;
  logic ack;
  cmd_t cmd;
  rsp_t result;

  // A request is in flight from its acceptance until its result is registered.
  assign req_stall = busy;
  assign start     = req_valid && !req_stall;
  // The engine result moves into the output register whenever that register is free
  // or is being emptied in this same cycle.
  assign ack       = done && (!rsp_valid || !rsp_stall);

  always_comb begin
    cmd.op         = req.mode;
    cmd.supported  = pair_known(req.unit, req.fault_code);
    cmd.unit       = req.unit;
    cmd.ftype      = req.fault_code;
    cmd.read_index = req.read_index;
    cmd.mask       = (req.mode == MODE_INJ_INST) ? sel_to_mask(req.instance_req)
                                                 : req.select_mask;
  end

  fmt_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .ack   (ack),
    .done  (done),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (ack) begin
        busy <= 1'b0;
      end
      if (ack) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      rsp <= result;
    end
  end

  // The engine only finishes work that was accepted and not yet delivered.
  `FMT_ASSERT_SAME(a_done_needs_busy, done, busy, "engine finished while no request was open")
  // An accepted transaction keeps the input side closed in the next cycle.
  `FMT_ASSERT_NEXT(a_accept_sets_busy, start, busy, "request accepted but input not stalled")
  // Only the defined status codes leave the block.
  `FMT_ASSERT_SAME(a_status_code, rsp_valid,
                   (rsp.status == ST_OK || rsp.status == ST_UNSUP || rsp.status == ST_FULL),
                   "undefined status code on the result")
  // A failed inject never reports slot contents.
  `FMT_ASSERT_SAME(a_fail_no_entry, rsp_valid && (rsp.status != ST_OK),
                   (rsp.entry_mask == '0 && rsp.entry_unit == '0 && rsp.entry_type == '0),
                   "slot contents reported on a failed request")

endmodule

/* verif/fault_mode_table_unit_tb.sv */
`timescale 1ns / 1ps

module fault_mode_table_unit_tb import fmt_pkg::*;;

  // The slowest correct run is about 1100 requests, each spending the engine's full inject
  // time plus the longest sender gap and receiver stall. The limit leaves several times
  // that margin.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to watch for stray responses after the last expected one has arrived.
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  fault_mode_table_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Requests waiting to be driven, and the responses predicted for requests that the
  // block has already taken.
  req_t requests_due[$];
  rsp_t table_replies_due[$];
  // Request indexes before which the driver waits until no response is outstanding.
  int drain_points[$];

  // Predicted state of the fault table.
  slot_t fault_slots[TABLE_DEPTH];
  int unsigned live_n = 0;
  bit flag_chg = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned n_loaded = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned n_inject_ok = 0;
  int unsigned n_unsup = 0;
  int unsigned n_full = 0;
  int unsigned n_read_live = 0;
  int unsigned n_clear = 0;
  bit calm = 1'b0;
  bit hold;
  rsp_t reply;
  rsp_t want;

  // Highest fault type that the catalogue allows for a unit, or -1 for an unknown unit.
  function automatic int top_fault_type(logic [7:0] u);
    int top;
    top = -1;
    if (u <= UNIT_DISTANCE) begin
      top = TYPE_STUCK;
    end else if (u <= UNIT_MOTOR) begin
      top = TYPE_WRONG;
    end else if (u <= UNIT_BATTERY) begin
      top = TYPE_OFF;
    end
    return top;
  endfunction

  // Instance number to instance bits: zero selects every instance, numbers past the
  // last instance select none.
  function automatic logic [15:0] instance_bits(logic [7:0] n);
    logic [15:0] b;
    b = '0;
    if (n == INST_ALL) begin
      b = MASK_ALL;
    end else if (n <= INST_LAST) begin
      b[4'(n - 8'd1)] = 1'b1;
    end
    return b;
  endfunction

  // Applies one inject to the predicted table and returns its status. A request that
  // needs a new slot in a full table leaves the table and the flag as they were.
  function automatic logic [1:0] predict_inject(logic [7:0] u, logic [7:0] t,
                                                logic [15:0] m);
    slot_t saved[TABLE_DEPTH];
    int unsigned saved_n;
    bit saved_chg;
    int unsigned r;
    int unsigned w;
    int unsigned hit;
    int top;
    top = top_fault_type(u);
    if (top < 0 || int'(t) > top) return ST_UNSUP;
    if (m == '0) return ST_OK;
    saved = fault_slots;
    saved_n = live_n;
    saved_chg = flag_chg;
    // Strip the instances from the unit's other types (all of them for "ok").
    for (r = 0; r < live_n; r++) begin
      if (fault_slots[r].unit == u && (t == TYPE_OK || fault_slots[r].ftype != t) &&
          (fault_slots[r].mask & m) != '0) begin
        fault_slots[r].mask = fault_slots[r].mask & ~m;
        flag_chg = 1'b1;
      end
    end
    // Drop emptied entries and keep the order of the rest.
    w = 0;
    for (r = 0; r < live_n; r++) begin
      if (fault_slots[r].mask != '0) begin
        fault_slots[w] = fault_slots[r];
        w++;
      end
    end
    for (r = w; r < TABLE_DEPTH; r++) fault_slots[r] = '0;
    live_n = w;
    if (t == TYPE_OK) return ST_OK;
    hit = TABLE_DEPTH;
    for (r = 0; r < live_n; r++) begin
      if (hit == TABLE_DEPTH && fault_slots[r].unit == u && fault_slots[r].ftype == t) begin
        hit = r;
      end
    end
    if (hit == TABLE_DEPTH) begin
      if (live_n >= TABLE_DEPTH) begin
        fault_slots = saved;
        live_n = saved_n;
        flag_chg = saved_chg;
        return ST_FULL;
      end
      hit = live_n;
      live_n++;
      fault_slots[hit].unit = u;
      fault_slots[hit].ftype = t;
      fault_slots[hit].mask = '0;
      flag_chg = 1'b1;
    end
    if ((fault_slots[hit].mask & m) != m) begin
      fault_slots[hit].mask = fault_slots[hit].mask | m;
      flag_chg = 1'b1;
    end
    return ST_OK;
  endfunction

  // Expected response to one accepted request; updates the predicted table.
  function automatic rsp_t fault_table_predict(req_t r);
    rsp_t e;
    e = '0;
    case (r.mode)
      MODE_INJ_INST: begin
        e.status = predict_inject(r.unit, r.fault_code, instance_bits(r.instance_req));
      end
      MODE_INJ_MASK: begin
        e.status = predict_inject(r.unit, r.fault_code, r.select_mask);
      end
      MODE_READ: begin
        if (r.read_index < live_n) begin
          e.entry_unit = fault_slots[r.read_index].unit;
          e.entry_type = fault_slots[r.read_index].ftype;
          e.entry_mask = fault_slots[r.read_index].mask;
        end
      end
      default: begin
        flag_chg = 1'b0;
      end
    endcase
    e.entry_count = 5'(live_n);
    e.changed = flag_chg;
    return e;
  endfunction

  function automatic void queue_request(logic [1:0] mode, logic [7:0] u, logic [7:0] t,
                                        logic [7:0] n, logic [15:0] m, logic [3:0] idx);
    req_t r;
    r.mode = mode;
    r.unit = u;
    r.fault_code = t;
    r.instance_req = n;
    r.select_mask = m;
    r.read_index = idx;
    requests_due.push_back(r);
  endfunction

  // Idle lengths: mostly none or short, now and then long. None while calm.
  function automatic int unsigned gap_length();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) begin
      len = 0;
    end else if (pick < 88) begin
      len = $urandom_range(1, 3);
    end else if (pick < 98) begin
      len = $urandom_range(4, 12);
    end else begin
      len = $urandom_range(20, 60);
    end
    return len;
  endfunction

  // A well-formed fill: clear every unit, inject every supported pair in random order
  // with instance bits that do not overlap between the types of one unit, so the table
  // fills up and the last pairs are refused. Two merges into entries already present
  // follow, which must succeed in a full table, and then every slot is read back.
  task automatic queue_fill_sequence();
    int pairs[$];
    int i;
    int j;
    int tmp;
    int u;
    int t;
    for (u = 0; u <= UNIT_BATTERY; u++) begin
      queue_request(MODE_INJ_MASK, 8'(u), TYPE_OK, 8'($urandom), MASK_ALL, 4'($urandom));
      for (t = TYPE_OFF; t <= top_fault_type(8'(u)); t++) pairs.push_back(u * 4 + t);
    end
    for (i = pairs.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pairs[i];
      pairs[i] = pairs[j];
      pairs[j] = tmp;
    end
    pairs.push_back(pairs[0]);
    pairs.push_back(pairs[1]);
    foreach (pairs[k]) begin
      u = pairs[k] / 4;
      t = pairs[k] % 4;
      if ($urandom_range(0, 1) == 0) begin
        queue_request(MODE_INJ_INST, 8'(u), 8'(t), 8'(t * 4 + $urandom_range(1, 4)),
                      16'($urandom), 4'($urandom));
      end else begin
        queue_request(MODE_INJ_MASK, 8'(u), 8'(t), 8'($urandom),
                      16'($urandom_range(1, 15) << (t * 4)), 4'($urandom));
      end
    end
    for (i = 0; i < TABLE_DEPTH; i++) begin
      queue_request(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                    4'(i));
    end
    queue_request(MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                  4'($urandom));
  endtask

  // Mostly supported pairs with random content; a minority of codes are arbitrary.
  task automatic queue_random_request();
    req_t r;
    int pick;
    int top;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.mode = MODE_INJ_INST;
    else if (pick < 65) r.mode = MODE_INJ_MASK;
    else if (pick < 88) r.mode = MODE_READ;
    else r.mode = MODE_CLEAR;
    r.unit = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, UNIT_BATTERY))
                                          : 8'($urandom);
    top = top_fault_type(r.unit);
    pick = $urandom_range(0, 99);
    if (pick < 15) r.fault_code = 8'($urandom);
    else if (pick < 35 || top < 0) r.fault_code = TYPE_OK;
    else r.fault_code = 8'($urandom_range(TYPE_OFF, top));
    pick = $urandom_range(0, 99);
    if (pick < 15) r.instance_req = INST_ALL;
    else if (pick < 70) r.instance_req = 8'($urandom_range(1, INST_LAST));
    else r.instance_req = 8'($urandom_range(INST_LAST + 1, 255));
    pick = $urandom_range(0, 99);
    if (pick < 30) r.select_mask = 16'd1 << $urandom_range(0, 15);
    else if (pick < 60) r.select_mask = 16'($urandom);
    else if (pick < 70) r.select_mask = '0;
    else if (pick < 80) r.select_mask = MASK_ALL;
    else r.select_mask = 16'($urandom) & 16'($urandom);
    r.read_index = 4'($urandom);
    requests_due.push_back(r);
  endtask

  function automatic void check_field(string name, logic [15:0] exp_val,
                                      logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Driver. A request stays on the bus until the block takes it; the response it must
  // produce is predicted at that edge. Idle gaps follow some transactions, and at each
  // drain point the driver holds off until every outstanding response has come back.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        reply = fault_table_predict(req);
        table_replies_due.push_back(reply);
        if (req.mode == MODE_CLEAR) n_clear++;
        else if (req.mode == MODE_READ) begin
          if (req.read_index < reply.entry_count) n_read_live++;
        end else if (reply.status == ST_UNSUP) n_unsup++;
        else if (reply.status == ST_FULL) n_full++;
        else n_inject_ok++;
      end
      if (!req_valid || !req_stall) begin
        hold = (drain_points.size() != 0 && drain_points[0] == n_loaded);
        if (hold && table_replies_due.size() == 0) begin
          void'(drain_points.pop_front());
          hold = 1'b0;
        end
        if (gap_left != 0) begin
          req_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (hold || requests_due.size() == 0) begin
          req_valid <= 1'b0;
        end else begin
          req <= requests_due.pop_front();
          req_valid <= 1'b1;
          n_loaded <= n_loaded + 1;
          gap_left <= gap_length();
        end
      end
    end
  end

  // Monitor. Every response transaction is compared field by field with the oldest
  // prediction. The stall toward the block comes in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (table_replies_due.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatches++;
        end else begin
          want = table_replies_due.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("entry_unit", want.entry_unit, rsp.entry_unit);
          check_field("entry_type", want.entry_type, rsp.entry_type);
          check_field("entry_mask", want.entry_mask, rsp.entry_mask);
          check_field("entry_count", want.entry_count, rsp.entry_count);
          check_field("changed", want.changed, rsp.changed);
        end
      end
      if (stall_left != 0) begin
        rsp_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        rsp_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left <= gap_length();
      end
    end
  end

  // Cycle limit, and the switch between stretches with and without idling.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ($urandom_range(0, 299) == 0) calm <= !calm;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Directed part: empty-table read, catalogue rejects at both ends of the codes,
    // instance number zero, one and sixteen, an instance number that selects nothing,
    // an empty mask, clearing by "ok", an inject that adds nothing after a flag clear,
    // an entry dropped when stripped empty, and reads inside and past the count.
    queue_request(MODE_READ, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd0);
    queue_request(MODE_CLEAR, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd0);
    queue_request(MODE_INJ_MASK, UNIT_BATTERY + 8'd1, TYPE_OFF, 8'd0, MASK_ALL, 4'd0);
    queue_request(MODE_INJ_INST, 8'hFF, 8'hFF, 8'hFF, MASK_ALL, 4'hF);
    queue_request(MODE_INJ_MASK, 8'd0, TYPE_WRONG, 8'd0, MASK_ALL, 4'd0);
    queue_request(MODE_INJ_MASK, 8'd8, TYPE_STUCK, 8'd0, MASK_ALL, 4'd0);
    queue_request(MODE_INJ_INST, 8'd0, TYPE_OFF, INST_ALL, 16'h0000, 4'd0);
    queue_request(MODE_INJ_INST, 8'd0, TYPE_STUCK, 8'd1, 16'h0000, 4'd0);
    queue_request(MODE_INJ_INST, 8'd5, TYPE_WRONG, INST_LAST, 16'h0000, 4'd0);
    queue_request(MODE_INJ_INST, UNIT_BATTERY, TYPE_OFF, INST_LAST + 8'd1, 16'h0000, 4'd0);
    queue_request(MODE_INJ_MASK, 8'd3, TYPE_STUCK, 8'd0, 16'h0000, 4'd0);
    queue_request(MODE_INJ_MASK, UNIT_MOTOR, TYPE_WRONG, 8'd0, MASK_ALL, 4'd0);
    queue_request(MODE_INJ_MASK, UNIT_MOTOR, TYPE_OK, 8'd0, 16'h8001, 4'd0);
    queue_request(MODE_CLEAR, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd0);
    queue_request(MODE_INJ_INST, 8'd5, TYPE_WRONG, INST_LAST, 16'h0000, 4'd0);
    queue_request(MODE_INJ_MASK, 8'd0, TYPE_STUCK, 8'd0, 16'hFFFE, 4'd0);
    queue_request(MODE_READ, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd0);
    queue_request(MODE_READ, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd1);
    queue_request(MODE_READ, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd2);
    queue_request(MODE_READ, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd15);
    queue_request(MODE_INJ_MASK, UNIT_BATTERY, TYPE_OFF, 8'd0, 16'hAAAA, 4'd0);
    queue_request(MODE_INJ_INST, UNIT_BATTERY, TYPE_OK, INST_ALL, 16'h0000, 4'd0);
    queue_request(MODE_READ, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd3);
    queue_request(MODE_CLEAR, 8'd0, TYPE_OK, 8'd0, 16'h0000, 4'd0);
    drain_points.push_back(requests_due.size());

    // Random part: fills of the whole table between runs of mixed requests, with a
    // full drain of the pipeline after each round.
    repeat (4) begin
      queue_fill_sequence();
      repeat (220) queue_random_request();
      drain_points.push_back(requests_due.size());
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (requests_due.size() != 0 || req_valid || table_replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests in %0d cycles: %0d injects taken, %0d catalogue rejects,",
             n_loaded, cycle_count, n_inject_ok, n_unsup);
    $display("%0d table-full rejects, %0d reads of live slots, %0d flag clears.",
             n_full, n_read_live, n_clear);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fmt_pkg.sv
rtl/fmt_slot_ram.sv
rtl/fmt_engine.sv
rtl/fault_mode_table_unit.sv
verif/fault_mode_table_unit_tb.sv
